FILE: sv/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
// no dependencies
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W      = 64;
  localparam int SLOT_W     = 10;
  localparam int POS_W      = 10;
  localparam int ENTRIES_W  = 11;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic REG_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE
  } state_t;

  typedef struct packed {
    logic write;
    logic start;
    logic step;
    logic rd_en;
    logic out_load;
    logic out_found;
  } dp_cmd_t;

  typedef struct packed {
    logic range_empty;
    logic step_empty;
    logic hit;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/stbs_ctrl.sv
// search sequencer: accepts words, starts searches, steps probes, hands off results
// depends on stbs_pkg
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_SEARCH) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.range_empty) begin
          if (!status.out_busy) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status.hit) begin
          if (!status.out_busy) begin
            state_next = ST_IDLE;
          end
        end else if (status.step_empty) begin
          state_next = ST_START;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.write = in_valid && in_cmd == CMD_LOAD;
        cmd.start = in_valid && in_cmd == CMD_SEARCH;
      end
      ST_START: begin
        if (status.range_empty) begin
          cmd.out_load = !status.out_busy;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_PROBE: begin
        if (status.hit) begin
          cmd.out_load  = !status.out_busy;
          cmd.out_found = 1'b1;
        end else begin
          cmd.step  = 1'b1;
          cmd.rd_en = !status.step_empty;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/stbs_dp.sv
// datapath: key table memory, search bounds, probe compare and result register
// depends on stbs_pkg
module stbs_dp
  import stbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [ENTRIES_W-1:0] entries,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [POS_W-1:0]     out_pos
);

  logic [KEY_W-1:0]  mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rdata;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  lo_step;
  logic [CNT_W-1:0]  hi_step;
  logic [CNT_W-1:0]  lo_next;
  logic [CNT_W-1:0]  hi_next;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] mid_next;
  logic [CNT_W:0]    mid_sum;
  logic              slot_ok;

  assign slot_ok = 32'(in_slot) < 32'(TABLE_DEPTH);

  // bounds after the current probe, whether or not it is taken
  always_comb begin
    lo_step = lo;
    hi_step = hi;
    if (key_q < rdata) begin
      hi_step = CNT_W'(mid);
    end else begin
      lo_step = CNT_W'(mid) + CNT_W'(1);
    end
  end

  assign lo_next = cmd.step ? lo_step : lo;
  assign hi_next = cmd.step ? hi_step : hi;

  // midpoint of the inclusive range lo .. hi-1
  assign mid_sum  = (CNT_W+1)'(lo_next) + (CNT_W+1)'(hi_next) - (CNT_W+1)'(1);
  assign mid_next = mid_sum[ADDR_W:1];

  assign status.range_empty = lo >= hi;
  assign status.step_empty  = lo_step >= hi_step;
  assign status.hit         = key_q == rdata;
  assign status.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) begin
      mem[ADDR_W'(in_slot)] <= in_key;
    end
    if (cmd.rd_en) begin
      rdata <= mem[mid_next];
      mid   <= mid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_q <= in_key;
      lo    <= '0;
      if (32'(entries) > 32'(TABLE_DEPTH)) begin
        hi <= CNT_W'(TABLE_DEPTH);
      end else begin
        hi <= CNT_W'(entries);
      end
    end else if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found <= cmd.out_found;
      out_pos   <= cmd.out_found ? POS_W'(mid) : '0;
    end
  end

endmodule

FILE: sv/sorted_table_binary_search.sv
// binary search over a sorted table of 64-bit keys, apb register for the entry count
// load word: accepted back to back; search word: input is held off until its result is loaded,
// up to log2(depth)+1 probes (11 for 1024 entries), and a miss that probed returns to start;
// each probe is one registered read of the single-port key memory and one compare
// result waits in an output register; a new word is taken while it waits
// rst is synchronous: clears sequencer, output valid and entry count; table is not cleared
module sorted_table_binary_search
  import stbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // slot[9:0], key[73:10], zero pad
  input  logic                  s_tuser,  // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // position[9:0], zero pad
  output logic                  m_tuser,  // found
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ENTRIES_W-1:0] entries_in_use;
  logic [POS_W-1:0]     position;
  dp_cmd_t              cmd;
  dp_status_t           status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRIES) begin
      entries_in_use <= pwdata[ENTRIES_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ENTRIES) ? APB_DATA_W'(entries_in_use) : '0;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_slot   (s_tdata[SLOT_W-1:0]),
    .in_key    (s_tdata[SLOT_W +: KEY_W]),
    .entries   (entries_in_use),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_found (m_tuser),
    .out_pos   (position)
  );

  assign m_tdata = OUT_DATA_W'(position);

endmodule

FILE: sv/stbs_chk.sv
// port-level checks for the sorted table binary search block, bound to the top level
// depends on stbs_pkg
module stbs_chk
  import stbs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with nonzero position");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_LOAD && !m_tvalid |=> !m_tvalid)
    else $error("load word produced a result");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_SEARCH |=> !s_tready)
    else $error("input taken during a search");

endmodule

bind sorted_table_binary_search stbs_chk u_stbs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/testbench.sv
// testbench for sorted_table_binary_search: loads key tables, sets the entry count
// over apb and checks every search result against a binary search model in a scoreboard
// depends on stbs_pkg and the sorted_table_binary_search rtl
`timescale 1ns / 1ps

module testbench;
  import stbs_pkg::*;

  localparam int WORD_TARGET   = 1550;
  localparam int CALM_WORDS    = 150;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int REG_SPARE     = 1;

  class search_scoreboard;
    typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
    } lookup_t;

    bit [KEY_W-1:0] key_table [TABLE_DEPTH];
    int             entries_in_use;
    lookup_t        expected_q [$];
    int             errors;

    function new();
      foreach (key_table[i]) key_table[i] = '0;
      entries_in_use = 0;
      errors = 0;
    endfunction

    function void write_entries(logic [APB_DATA_W-1:0] value);
      entries_in_use = int'(value[ENTRIES_W-1:0]);
    endfunction

    function int active_entries();
      return (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : entries_in_use;
    endfunction

    function void note_input(logic cmd, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key);
      int      low;
      int      high;
      int      mid;
      lookup_t hit;
      if (cmd == CMD_LOAD) begin
        if (int'(slot) < TABLE_DEPTH) key_table[slot] = key;
        return;
      end
      hit = '0;
      low = 0;
      high = active_entries() - 1;
      while (low <= high && !hit.found) begin
        mid = (low + high) / 2;
        if (key == key_table[mid]) begin
          hit.found = 1'b1;
          hit.position = mid[POS_W-1:0];
        end else if (key < key_table[mid]) begin
          high = mid - 1;
        end else begin
          low = mid + 1;
        end
      end
      expected_q.push_back(hit);
    endfunction

    function void check_result(logic found, logic [OUT_DATA_W-1:0] data);
      lookup_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, found %0b position %0d", $time, found, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (found !== want.found) begin
        $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, found);
        errors++;
      end
      if (data !== OUT_DATA_W'(want.position)) begin
        $display("%0t: position mismatch, expected %0d actual %0d",
                 $time, want.position, data);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  search_scoreboard sb;
  bit               idle_on = 1'b1;
  bit               hold_request = 1'b0;
  bit               table_full = 1'b0;
  int               words_sent = 0;
  int               stall_cycles = 0;

  wire moving = (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pwrite && pready);

  sorted_table_binary_search uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // words of up to 8 letters, big-endian and zero padded, or raw 64-bit values
  function automatic logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] w;
    int               len;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    len = $urandom_range(1, 8);
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w = {w[KEY_W-9:0], (i < len) ? 8'($urandom_range(97, 122)) : 8'h00};
    end
    return w;
  endfunction

  task automatic send_word(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input logic [KEY_W-1:0] key);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {{(IN_DATA_W-KEY_W-SLOT_W){1'b0}}, key, slot};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, slot, key);
    words_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == int'(REG_ENTRIES)) sb.write_entries(value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // loads slots 0..n-1, sets the entry count, then searches mostly for stored keys
  task automatic run_phase(input int n, input logic [APB_DATA_W-1:0] count_word,
                           input int searches, input bit sorted, input bit hold);
    logic [KEY_W-1:0] keys [];
    int               order [];
    int               live;
    int               r;
    logic [KEY_W-1:0] target;
    keys = new[n];
    order = new[n];
    foreach (keys[i]) begin
      keys[i] = (i > 0 && $urandom_range(0, 9) == 0) ? keys[i-1] : make_key();
      order[i] = i;
    end
    if (sorted) keys.sort();
    order.shuffle();
    foreach (order[i]) send_word(CMD_LOAD, SLOT_W'(order[i]), keys[order[i]]);
    settle();
    reg_write(int'(REG_ENTRIES), count_word);
    live = sb.active_entries();
    if (hold) hold_request = 1'b1;
    repeat (searches) begin
      if (!hold && $urandom_range(0, 24) == 0) begin
        send_word(CMD_LOAD, SLOT_W'($urandom), make_key());
      end
      r = $urandom_range(0, 9);
      if (live > 0 && r < 6) begin
        target = sb.key_table[$urandom_range(0, live - 1)];
      end else if (live > 0 && r < 8) begin
        target = sb.key_table[$urandom_range(0, live - 1)] + (r[0] ? 64'd1 : ~64'd0);
      end else begin
        target = make_key();
      end
      send_word(CMD_SEARCH, SLOT_W'($urandom), target);
    end
    settle();
  endtask

  initial begin
    logic [KEY_W-1:0] seed_keys [8];
    int               phase;
    int               n;
    int               r;
    logic [APB_DATA_W-1:0] count_word;
    seed_keys = '{64'h0, 64'h1, 64'h6100000000000000, 64'h6162000000000000,
                  64'h7468650000000000, 64'h7a7a7a7a7a7a7a7a, 64'h8000000000000000,
                  64'hffffffffffffffff};
    sb = new();
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_LOAD;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table
    reg_write(int'(REG_ENTRIES), 0);
    send_word(CMD_SEARCH, '0, 64'h0);
    send_word(CMD_SEARCH, '1, 64'hffffffffffffffff);

    // small sorted table with both key extremes
    foreach (seed_keys[i]) send_word(CMD_LOAD, SLOT_W'(i), seed_keys[i]);
    settle();
    reg_write(int'(REG_ENTRIES), 8);
    send_word(CMD_SEARCH, '0, 64'h0);
    send_word(CMD_SEARCH, '0, 64'hffffffffffffffff);
    send_word(CMD_SEARCH, '0, 64'h7468650000000000);
    send_word(CMD_SEARCH, '0, 64'h6162630000000000);
    send_word(CMD_SEARCH, '0, 64'h2);
    send_word(CMD_SEARCH, '0, 64'h7fffffffffffffff);

    // duplicate key, then a table that is no longer sorted
    send_word(CMD_LOAD, 10'd3, 64'h6100000000000000);
    send_word(CMD_SEARCH, '0, 64'h6100000000000000);
    send_word(CMD_LOAD, 10'd0, 64'hffffffffffffffff);
    send_word(CMD_SEARCH, '0, 64'hffffffffffffffff);

    // single entry, and a write to an unused register that must change nothing
    settle();
    reg_write(int'(REG_ENTRIES), 1);
    send_word(CMD_SEARCH, '0, 64'hffffffffffffffff);
    send_word(CMD_SEARCH, '0, 64'h0);
    settle();
    reg_write(REG_SPARE, 0);
    send_word(CMD_SEARCH, '0, 64'hffffffffffffffff);
    settle();

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      idle_on = (words_sent < WORD_TARGET - CALM_WORDS) && ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        // full table, then counts past the table depth, first with junk in the upper bits
        run_phase(TABLE_DEPTH, TABLE_DEPTH, 60, 1'b1, 1'b1);
        table_full = 1'b1;
        run_phase(0, {21'($urandom), 11'h7ff}, 30, 1'b1, 1'b0);
        run_phase(0, TABLE_DEPTH + 1, 10, 1'b1, 1'b0);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32);
        r = $urandom_range(0, 9);
        if (table_full && r == 0) count_word = $urandom;
        else if (r < 3) count_word = $urandom_range(0, n);
        else count_word = n;
        run_phase(n, count_word, $urandom_range(4, 24), $urandom_range(0, 7) != 0, 1'b0);
      end
      phase++;
    end

    settle();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (moving) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
